/* rtl/core/sum_checked_frame_deframer_top_defines.svh */
// ----------------------------------------------------------------------------
// Sum-checked frame deframer: assertion macros
// Shared property wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SUM_CHECKED_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCFD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SCFD_ASSERT_NOW(lbl, ante, cons, msg)
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/scfd_pkg.sv */
// ----------------------------------------------------------------------------
// Sum-checked frame deframer package
// Widths, protocol codes, parse phases and the result word layout.
// ----------------------------------------------------------------------------
package scfd_pkg;

   localparam int RX_W     = 8;
   localparam int SC_W     = 14;
   localparam int IDX_W    = 14;
   localparam int VAL_W    = 12;
   localparam int TDATA_W  = 56;
   localparam int TUSER_W  = 1;

   localparam int          SPP_DEFAULT = 32;
   localparam logic [SC_W-1:0] SC_RESET = 14'd512;

   localparam logic [RX_W-1:0] HDR_BYTE    = 8'h68;
   localparam logic [RX_W-1:0] CMD_SAMPLES = 8'h03;
   localparam logic [RX_W-1:0] SHORT_CODE  = 8'h03;
   localparam logic [RX_W-1:0] LEN_SHORT   = 8'h01;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_CMD,
      PH_SEQ,
      PH_LEN,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_SUM,
      ST_SHORT
   } status_type;

   typedef enum logic {
      KIND_SAMPLE,
      KIND_REPORT
   } kind_type;

   typedef struct packed {
      logic                    valid;
      kind_type                kind;
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] value;
      logic [RX_W-1:0]         command;
      logic [RX_W-1:0]         sequence_no;
      logic [RX_W-1:0]         length;
      status_type              status;
      logic                    final_pack;
   } result_type;

endpackage

/* rtl/core/sum_checked_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// Sum-checked frame deframer
// Byte-stream deframer: header 0x68, command, sequence, length, payload and
// sum-mod-256 checksum; decodes command-3 samples and reports each frame.
//
//   channel  dir  payload
//   req_     in   tdata[7:0] rx_byte
//   rsp_     out  tdata: index, value, command, sequence, length, status, final
//                 tuser[0]: item kind (0 sample, 1 frame report)
//   csr_     in   data[13:0] sample_count
//
// One word per cycle in while req_tready is high, at most one result per word, registered and shown the cycle after.
// The result register decouples the sides: req_tready drops only while a
// result is held and rsp_tready is low.
// Synchronous active-high reset; sample_count resets to 512.
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer_top #(
   parameter int SAMPLES_PER_PACK = scfd_pkg::SPP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [scfd_pkg::RX_W-1:0]     req_tdata,   // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [13:0] sample_index, [25:14] sample_value, [33:26] frame_command,
   // [41:34] frame_sequence, [49:42] frame_length, [51:50] frame_status,
   // [52] final_pack, [55:53] zero
   output logic [scfd_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic [scfd_pkg::TUSER_W-1:0]  rsp_tuser,   // [0] item_kind
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [scfd_pkg::SC_W-1:0]     csr_data     // [13:0] sample_count
);
   import scfd_pkg::*;

   logic       byte_accept;
   logic       in_ready;
   result_type result;
   result_type item;

   assign req_tready  = in_ready;
   assign byte_accept = req_tvalid && in_ready;
   assign csr_ready   = 1'b1;

   scfd_parser #(
      .SAMPLES_PER_PACK (SAMPLES_PER_PACK)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .csr_write   (csr_valid),
      .csr_value   (csr_data),
      .result      (result)
   );

   scfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .item      (item),
      .in_ready  (in_ready)
   );

   assign rsp_tdata = {3'b000, item.final_pack, item.status, item.length,
                       item.sequence_no, item.command, item.value, item.index};
   assign rsp_tuser = item.kind;

endmodule

/* rtl/core/scfd_parser.sv */
// ----------------------------------------------------------------------------
// Frame parser
// Header hunt, field capture, running sum, sample decode and frame report.
// ----------------------------------------------------------------------------
module scfd_parser #(
   parameter int SAMPLES_PER_PACK = scfd_pkg::SPP_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_accept,
   input  logic [scfd_pkg::RX_W-1:0]    rx_byte,
   input  logic                         csr_write,
   input  logic [scfd_pkg::SC_W-1:0]    csr_value,
   output scfd_pkg::result_type         result
);
   import scfd_pkg::*;

`include "sum_checked_frame_deframer_top_defines.svh"

   localparam int BASE_W = RX_W + $clog2(SAMPLES_PER_PACK + 1);
   localparam int CMP_W  = (BASE_W > SC_W) ? BASE_W : SC_W;
   localparam logic [BASE_W-1:0] SPP = BASE_W'(SAMPLES_PER_PACK);

   phase_type         state_ff, state_in;
   logic [RX_W-1:0]   cmd_ff, cmd_in;
   logic [RX_W-1:0]   seq_ff, seq_in;
   logic [RX_W-1:0]   len_ff, len_in;
   logic [RX_W-1:0]   cnt_ff, cnt_in;
   logic [RX_W-1:0]   sum_ff, sum_in;
   logic [RX_W-1:0]   low_ff, low_in;
   logic [RX_W-1:0]   first_ff, first_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [SC_W-1:0]   sc_ff, sc_in;

   logic [RX_W:0]     cnt_next;
   logic [RX_W-1:0]   sum_add;
   logic [BASE_W-1:0] base_top;
   logic [CMP_W-1:0]  idx_full;
   status_type        status;
   logic              last_pack;

   assign cnt_next = {1'b0, cnt_ff} + {{RX_W{1'b0}}, 1'b1};
   assign sum_add  = sum_ff + rx_byte;
   assign base_top = base_ff + SPP;
   assign idx_full = CMP_W'(base_ff) + CMP_W'(cnt_ff[RX_W-1:1]);

   // next phase
   always_comb begin
      state_in = state_ff;
      if (byte_accept) begin
         case (state_ff)
            PH_HUNT:    state_in = (rx_byte == HDR_BYTE) ? PH_CMD : PH_HUNT;
            PH_CMD:     state_in = PH_SEQ;
            PH_SEQ:     state_in = PH_LEN;
            PH_LEN:     state_in = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            PH_PAYLOAD: state_in = (cnt_next >= {1'b0, len_ff}) ? PH_CHECK : PH_PAYLOAD;
            PH_CHECK:   state_in = PH_HUNT;
            default:    state_in = PH_HUNT;
         endcase
      end
   end

   // field capture
   always_comb begin
      cmd_in   = cmd_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      low_in   = low_ff;
      first_in = first_ff;
      base_in  = base_ff;
      sc_in    = csr_write ? csr_value : sc_ff;
      if (byte_accept) begin
         case (state_ff)
            PH_HUNT: begin
               if (rx_byte == HDR_BYTE) begin
                  sum_in = HDR_BYTE;
               end
            end
            PH_CMD: begin
               cmd_in = rx_byte;
               sum_in = sum_add;
            end
            PH_SEQ: begin
               seq_in  = rx_byte;
               sum_in  = sum_add;
               base_in = BASE_W'(rx_byte) * SPP;
            end
            PH_LEN: begin
               len_in   = rx_byte;
               sum_in   = sum_add;
               cnt_in   = '0;
               first_in = '0;
               low_in   = '0;
            end
            PH_PAYLOAD: begin
               sum_in = sum_add;
               cnt_in = cnt_next[RX_W-1:0];
               if (cnt_ff == '0) begin
                  first_in = rx_byte;
               end
               if (!cnt_ff[0]) begin
                  low_in = rx_byte;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // frame report terms
   always_comb begin
      if (rx_byte != sum_ff) begin
         status = ST_BAD_SUM;
      end else if (cmd_ff == CMD_SAMPLES && len_ff == LEN_SHORT && first_ff == SHORT_CODE) begin
         status = ST_SHORT;
      end else begin
         status = ST_OK;
      end
      // seq == count / spp, or count == spp * (seq + 1)
      last_pack = (status == ST_OK) && (cmd_ff == CMD_SAMPLES) &&
                  (CMP_W'(sc_ff) >= CMP_W'(base_ff)) &&
                  (CMP_W'(sc_ff) <= CMP_W'(base_top));
   end

   // result word
   always_comb begin
      result = '0;
      case (state_ff)
         PH_PAYLOAD: begin
            if (cnt_ff[0] && cmd_ff == CMD_SAMPLES) begin
               result.valid = byte_accept;
               result.kind  = KIND_SAMPLE;
               result.index = idx_full[IDX_W-1:0];
               result.value = {rx_byte[3:0], low_ff};
            end
         end
         PH_CHECK: begin
            result.valid       = byte_accept;
            result.kind        = KIND_REPORT;
            result.command     = cmd_ff;
            result.sequence_no = seq_ff;
            result.length      = len_ff;
            result.status      = status;
            result.final_pack  = last_pack;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_HUNT;
         cmd_ff   <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         low_ff   <= '0;
         first_ff <= '0;
         sc_ff    <= SC_RESET;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         low_ff   <= low_in;
         first_ff <= first_in;
         sc_ff    <= sc_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   `SCFD_ASSERT_NEXT(a_check_returns_to_hunt, byte_accept && state_ff == PH_CHECK, state_ff == PH_HUNT, "frame end did not return to header hunt")
   `SCFD_ASSERT_NOW(a_sample_needs_cmd3, result.valid && result.kind == KIND_SAMPLE, cmd_ff == CMD_SAMPLES && state_ff == PH_PAYLOAD, "sample outside a command-3 payload")
   `SCFD_ASSERT_NOW(a_final_only_ok, result.valid && result.final_pack, result.status == ST_OK && result.kind == KIND_REPORT, "final pack flagged on a bad frame")

endmodule

/* rtl/core/scfd_out_reg.sv */
// ----------------------------------------------------------------------------
// Result register
// One-entry output register; frees the input side as soon as it drains.
// ----------------------------------------------------------------------------
module scfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  scfd_pkg::result_type result,
   input  logic                 out_ready,
   output logic                 out_valid,
   output scfd_pkg::result_type item,
   output logic                 in_ready
);
   import scfd_pkg::*;

`include "sum_checked_frame_deframer_top_defines.svh"

   logic       valid_ff, valid_in;
   result_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = result.valid || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         item_ff <= result;
      end
   end

   `SCFD_ASSERT_NOW(a_no_load_when_full, valid_ff && !out_ready, !result.valid, "new word while result register is stalled")
   `SCFD_ASSERT_NEXT(a_load_shows, result.valid, valid_ff, "loaded word not presented")
   `SCFD_ASSERT_NOW(a_report_clean, valid_ff && item_ff.kind == KIND_REPORT, item_ff.index == '0 && item_ff.value == '0, "frame report carries sample fields")

endmodule
